FILE: rtl/rsd_pkg.sv
// Route-sheet stream decoder: shared types, codes and the CRC-16 byte update.
// No dependencies; used by the top level, the interfaces' users and the checker.
`default_nettype none

package rsd_pkg;

  // Longest label prefix that is forwarded per segment
  localparam int unsigned MAX_LABEL = 32;
  localparam int unsigned LBL_W     = $clog2(MAX_LABEL + 1);

  // Result queue
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Configuration register indexes
  localparam logic [0:0] REG_VERSION = 1'b0;
  localparam logic [0:0] REG_LIMIT   = 1'b1;

  localparam logic [7:0] VERSION_RST = 8'd1;
  localparam logic [7:0] LIMIT_RST   = 8'd32;

  // Result kinds
  localparam logic [1:0] KIND_SEG    = 2'd0;
  localparam logic [1:0] KIND_LABEL  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes; short, then crc, then the recorded error, then truncated
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_CRC       = 3'd2;
  localparam logic [2:0] ST_VERSION   = 3'd3;
  localparam logic [2:0] ST_TOO_MANY  = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;
  localparam logic [2:0] ST_TRAILING  = 3'd6;

  typedef enum logic [10:0] {
    PH_VERSION = 11'b000_0000_0001,
    PH_COUNT   = 11'b000_0000_0010,
    PH_HDR0    = 11'b000_0000_0100,
    PH_HDR1    = 11'b000_0000_1000,
    PH_HDR2    = 11'b000_0001_0000,
    PH_HDR3    = 11'b000_0010_0000,
    PH_HDR4    = 11'b000_0100_0000,
    PH_HDR5    = 11'b000_1000_0000,
    PH_LABEL   = 11'b001_0000_0000,
    PH_DONE    = 11'b010_0000_0000,
    PH_HALT    = 11'b100_0000_0000
  } rsd_phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  seg_index;
    logic [15:0] dist_milli;
    logic [15:0] speed_deci;
    logic        speed_given;
    logic        dist_restart;
    logic        is_free;
    logic [3:0]  chk_class;
    logic [7:0]  label_char;
    logic [2:0]  status_code;
    logic        end_mark;
  } rsd_item_t;

  // CRC-16, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rsd_if.sv
// Valid/ready channel interfaces of the route-sheet stream decoder.
// rsd_byte_if carries message bytes in, rsd_item_if carries result items out.
`default_nettype none

interface rsd_byte_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface rsd_item_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  seg_index;
  logic [15:0] dist_milli;
  logic [15:0] speed_deci;
  logic        speed_given;
  logic        dist_restart;
  logic        is_free;
  logic [3:0]  chk_class;
  logic [7:0]  label_char;
  logic [2:0]  status_code;
  logic        end_mark;

  modport source (output valid, kind, seg_index, dist_milli, speed_deci, speed_given,
                  dist_restart, is_free, chk_class, label_char, status_code, end_mark,
                  input ready);
  modport sink   (input valid, kind, seg_index, dist_milli, speed_deci, speed_given,
                  dist_restart, is_free, chk_class, label_char, status_code, end_mark,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/route_sheet_stream_decoder_top.sv
// Route-sheet stream decoder top level: CRC, field parser and result queue.
// Depends on rsd_pkg and the channel interfaces in rsd_if.sv.
//
//   channel   dir  handshake        payload
//   in_if     in   valid/ready      data_byte, last_byte
//   out_if    out  valid/ready      kind .. end_mark (one result item)
//   cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i (write only)
//
// One byte per cycle: CRC update and parse of the byte leaving the two-byte
// hold-back happen in the accepting cycle; items land in a 4-entry queue and
// can be taken the next cycle. A last byte may push two items; in_if.ready
// drops while the queue holds more than two, so output stalls back up input.
// Reset returns registers to their defaults and clears all message state.
`default_nettype none

module route_sheet_stream_decoder_top
  import rsd_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  rsd_byte_if.sink    in_if,
  rsd_item_if.source  out_if,
  input  wire         cfg_we_i,
  input  wire  [0:0]  cfg_idx_i,
  input  wire  [7:0]  cfg_data_i
);

  logic [7:0]       ver_q, limit_q;
  logic [7:0]       held_q [2];
  logic [7:0]       held_d [2];
  logic [2:0]       seen_q, seen_d;
  logic [15:0]      crc_q, crc_d;
  rsd_phase_e       phase_q, phase_d;
  logic [15:0]      dist_q, dist_d;
  logic [15:0]      speed_q, speed_d;
  logic [7:0]       flags_q, flags_d;
  logic [7:0]       total_q, total_d;
  logic [7:0]       done_q, done_d;
  logic [7:0]       left_q, left_d;
  logic [LBL_W-1:0] kept_q, kept_d;
  logic [2:0]       err_q, err_d;

  rsd_item_t        oq_q [OQ_DEPTH];
  logic [OQ_PW-1:0] wr_q, rd_q;
  logic [OQ_CW-1:0] cnt_q;

  logic       acc, pop, seg_end, a_vld;
  logic [7:0] p, done_inc;
  logic [2:0] st;
  rsd_item_t  item_a, item_b, head;

  assign acc = in_if.valid & in_if.ready;
  assign pop = out_if.valid & out_if.ready;
  assign p   = held_q[0];
  assign done_inc = done_q + 8'd1;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_q   <= VERSION_RST;
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VERSION: ver_q   <= cfg_data_i;
        REG_LIMIT:   limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    held_d  = held_q;
    seen_d  = seen_q;
    crc_d   = crc_q;
    phase_d = phase_q;
    dist_d  = dist_q;
    speed_d = speed_q;
    flags_d = flags_q;
    total_d = total_q;
    done_d  = done_q;
    left_d  = left_q;
    kept_d  = kept_q;
    err_d   = err_q;
    item_a  = '0;
    item_b  = '0;
    a_vld   = 1'b0;
    seg_end = 1'b0;
    st      = ST_OK;
    if (acc) begin
      if (seen_q >= 3'd2) begin
        crc_d = crc16_byte(crc_q, p);
        case (phase_q)
          PH_VERSION: begin
            if (p != ver_q) begin
              err_d   = ST_VERSION;
              phase_d = PH_HALT;
            end else begin
              phase_d = PH_COUNT;
            end
          end
          PH_COUNT: begin
            total_d = p;
            done_d  = '0;
            if (p > limit_q) begin
              err_d   = ST_TOO_MANY;
              phase_d = PH_HALT;
            end else begin
              phase_d = (p == 8'd0) ? PH_DONE : PH_HDR0;
            end
          end
          PH_HDR0: begin dist_d[7:0]   = p; phase_d = PH_HDR1; end
          PH_HDR1: begin dist_d[15:8]  = p; phase_d = PH_HDR2; end
          PH_HDR2: begin speed_d[7:0]  = p; phase_d = PH_HDR3; end
          PH_HDR3: begin speed_d[15:8] = p; phase_d = PH_HDR4; end
          PH_HDR4: begin flags_d       = p; phase_d = PH_HDR5; end
          PH_HDR5: begin
            a_vld               = 1'b1;
            item_a.kind         = KIND_SEG;
            item_a.seg_index    = done_q;
            item_a.dist_milli   = dist_q;
            item_a.speed_deci   = flags_q[2] ? speed_q : 16'd0;
            item_a.speed_given  = flags_q[2];
            item_a.dist_restart = flags_q[0];
            item_a.is_free      = flags_q[1];
            item_a.chk_class    = flags_q[7:4];
            left_d = p;
            kept_d = '0;
            if (p == 8'd0) begin
              seg_end = 1'b1;
            end else begin
              phase_d = PH_LABEL;
            end
          end
          PH_LABEL: begin
            if (kept_q < LBL_W'(MAX_LABEL)) begin
              a_vld             = 1'b1;
              item_a.kind       = KIND_LABEL;
              item_a.seg_index  = done_q;
              item_a.label_char = p;
              kept_d            = kept_q + 1'b1;
            end
            left_d = left_q - 8'd1;
            if (left_q == 8'd1) begin
              seg_end = 1'b1;
            end
          end
          PH_DONE: begin
            err_d   = ST_TRAILING;
            phase_d = PH_HALT;
          end
          default: ;
        endcase
        if (seg_end) begin
          done_d  = done_inc;
          phase_d = (done_inc == total_q) ? PH_DONE : PH_HDR0;
        end
        held_d[0] = held_q[1];
        held_d[1] = in_if.data_byte;
      end else begin
        held_d[seen_q[0]] = in_if.data_byte;
      end
      if (seen_q < 3'd4) begin
        seen_d = seen_q + 3'd1;
      end

      if (in_if.last_byte) begin
        if (seen_d < 3'd4) begin
          st = ST_SHORT;
        end else if (crc_d != {held_d[1], held_d[0]}) begin
          st = ST_CRC;
        end else if (err_d != ST_OK) begin
          st = err_d;
        end else if (phase_d != PH_DONE) begin
          st = ST_TRUNCATED;
        end else begin
          st = ST_OK;
        end
        item_b.kind        = KIND_STATUS;
        item_b.seg_index   = total_d;
        item_b.status_code = st;
        item_b.end_mark    = 1'b1;
        // message state back to its reset values
        held_d[0] = '0;
        held_d[1] = '0;
        seen_d  = '0;
        crc_d   = CRC_INIT;
        phase_d = PH_VERSION;
        dist_d  = '0;
        speed_d = '0;
        flags_d = '0;
        total_d = '0;
        done_d  = '0;
        left_d  = '0;
        kept_d  = '0;
        err_d   = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q[0] <= '0;
      held_q[1] <= '0;
      seen_q  <= '0;
      crc_q   <= CRC_INIT;
      phase_q <= PH_VERSION;
      dist_q  <= '0;
      speed_q <= '0;
      flags_q <= '0;
      total_q <= '0;
      done_q  <= '0;
      left_q  <= '0;
      kept_q  <= '0;
      err_q   <= ST_OK;
    end else begin
      held_q  <= held_d;
      seen_q  <= seen_d;
      crc_q   <= crc_d;
      phase_q <= phase_d;
      dist_q  <= dist_d;
      speed_q <= speed_d;
      flags_q <= flags_d;
      total_q <= total_d;
      done_q  <= done_d;
      left_q  <= left_d;
      kept_q  <= kept_d;
      err_q   <= err_d;
    end
  end

  // Result queue: up to two writes per transaction, one read
  logic             push_a, push_b;
  logic [OQ_PW-1:0] wr_b;

  assign push_a = acc & a_vld;
  assign push_b = acc & in_if.last_byte;
  assign wr_b   = wr_q + OQ_PW'(push_a);

  always_ff @(posedge clk_i) begin
    if (push_a) begin
      oq_q[wr_q] <= item_a;
    end
    if (push_b) begin
      oq_q[wr_b] <= item_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + OQ_PW'(push_a) + OQ_PW'(push_b);
      rd_q  <= rd_q + OQ_PW'(pop);
      cnt_q <= cnt_q + OQ_CW'(push_a) + OQ_CW'(push_b) - OQ_CW'(pop);
    end
  end

  assign in_if.ready = (cnt_q <= OQ_CW'(OQ_DEPTH - 2));

  assign head                = oq_q[rd_q];
  assign out_if.valid        = (cnt_q != '0);
  assign out_if.kind         = head.kind;
  assign out_if.seg_index    = head.seg_index;
  assign out_if.dist_milli   = head.dist_milli;
  assign out_if.speed_deci   = head.speed_deci;
  assign out_if.speed_given  = head.speed_given;
  assign out_if.dist_restart = head.dist_restart;
  assign out_if.is_free      = head.is_free;
  assign out_if.chk_class    = head.chk_class;
  assign out_if.label_char   = head.label_char;
  assign out_if.status_code  = head.status_code;
  assign out_if.end_mark     = head.end_mark;

endmodule

`default_nettype wire

FILE: rtl/rsd_checker.sv
// Port-level checks for the route-sheet stream decoder, bound to its top level.
// Depends on rsd_pkg for result kinds and status codes.
`default_nettype none

module rsd_checker
  import rsd_pkg::*;
(
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        in_last_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [1:0]  out_kind_i,
  input wire [2:0]  out_status_i,
  input wire        out_end_i,
  input wire        out_speed_given_i,
  input wire [15:0] out_speed_i
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Closing a message always leaves a status item to deliver
  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> out_valid_i)
    else $error("no result after last byte");

  a_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_end_i == (out_kind_i == KIND_STATUS)))
    else $error("end mark does not match status kind");

  a_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != KIND_STATUS) |-> (out_status_i == ST_OK))
    else $error("status code on a non-status item");

  a_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_speed_given_i |-> (out_speed_i == 16'd0))
    else $error("speed without speed flag");

endmodule

bind route_sheet_stream_decoder_top rsd_checker u_rsd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_if.valid),
  .in_ready_i        (in_if.ready),
  .in_last_i         (in_if.last_byte),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .out_kind_i        (out_if.kind),
  .out_status_i      (out_if.status_code),
  .out_end_i         (out_if.end_mark),
  .out_speed_given_i (out_if.speed_given),
  .out_speed_i       (out_if.speed_deci)
);

`default_nettype wire

FILE: tb/rsd_checker.sv
// Route-sheet decoder checker: byte-level predictor of the decoder plus an in-order
// comparison of every result transaction. Depends on rsd_pkg and the interfaces in rsd_if.sv.
package rsd_tb_pkg;
  import rsd_pkg::*;

  // CRC-16 over one byte, one message bit at a time, MSB first
  function automatic logic [15:0] crc_ccitt_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction
endpackage

module rsd_tb_checker
  import rsd_pkg::*;
  import rsd_tb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rsd_byte_if        in_if,
  rsd_item_if        out_if,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  rsd_item_t   expected_items[$];
  int          fail_count = 0;
  int          pending = 0;

  logic [7:0]  proto_version;
  logic [7:0]  seg_limit;

  // per-message decoder state
  logic [7:0]  held [2];
  logic [2:0]  bytes_seen;
  logic [15:0] crc_run;
  rsd_phase_e  phase;
  logic [7:0]  hdr [5];
  logic [7:0]  seg_total;
  logic [7:0]  seg_done;
  logic [7:0]  label_left;
  logic [5:0]  label_kept;
  logic [2:0]  first_err;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  task automatic clear_message();
    held[0]    = '0;
    held[1]    = '0;
    bytes_seen = '0;
    crc_run    = CRC_INIT;
    phase      = PH_VERSION;
    for (int i = 0; i < 5; i++) begin
      hdr[i] = '0;
    end
    seg_total  = '0;
    seg_done   = '0;
    label_left = '0;
    label_kept = '0;
    first_err  = ST_OK;
  endtask

  task automatic finish_segment();
    seg_done = seg_done + 8'd1;
    phase    = (seg_done == seg_total) ? PH_DONE : PH_HDR0;
  endtask

  // One byte that has left the CRC hold-back
  task automatic decode_payload(input logic [7:0] b);
    rsd_item_t item;
    item = '0;
    case (phase)
      PH_VERSION: begin
        if (b != proto_version) begin
          first_err = ST_VERSION;
          phase     = PH_HALT;
        end else begin
          phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        seg_total = b;
        seg_done  = '0;
        if (b > seg_limit) begin
          first_err = ST_TOO_MANY;
          phase     = PH_HALT;
        end else begin
          phase = (b == 8'd0) ? PH_DONE : PH_HDR0;
        end
      end
      PH_HDR0: begin hdr[0] = b; phase = PH_HDR1; end
      PH_HDR1: begin hdr[1] = b; phase = PH_HDR2; end
      PH_HDR2: begin hdr[2] = b; phase = PH_HDR3; end
      PH_HDR3: begin hdr[3] = b; phase = PH_HDR4; end
      PH_HDR4: begin hdr[4] = b; phase = PH_HDR5; end
      PH_HDR5: begin
        // hdr[4] is the flags byte, b is the label length
        item.kind         = KIND_SEG;
        item.seg_index    = seg_done;
        item.dist_milli   = {hdr[1], hdr[0]};
        item.speed_deci   = hdr[4][2] ? {hdr[3], hdr[2]} : 16'd0;
        item.speed_given  = hdr[4][2];
        item.dist_restart = hdr[4][0];
        item.is_free      = hdr[4][1];
        item.chk_class    = hdr[4][7:4];
        expected_items.push_back(item);
        label_left = b;
        label_kept = '0;
        if (b == 8'd0) begin
          finish_segment();
        end else begin
          phase = PH_LABEL;
        end
      end
      PH_LABEL: begin
        if (label_kept < MAX_LABEL) begin
          item.kind       = KIND_LABEL;
          item.seg_index  = seg_done;
          item.label_char = b;
          expected_items.push_back(item);
          label_kept = label_kept + 6'd1;
        end
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) begin
          finish_segment();
        end
      end
      PH_DONE: begin
        first_err = ST_TRAILING;
        phase     = PH_HALT;
      end
      default: ;
    endcase
  endtask

  task automatic accept_byte(input logic [7:0] b, input logic last);
    rsd_item_t status;
    logic [2:0] code;
    if (bytes_seen >= 3'd2) begin
      crc_run = crc_ccitt_next(crc_run, held[0]);
      decode_payload(held[0]);
      held[0] = held[1];
      held[1] = b;
    end else begin
      held[bytes_seen[0]] = b;
    end
    if (bytes_seen < 3'd4) begin
      bytes_seen = bytes_seen + 3'd1;
    end
    if (last) begin
      if (bytes_seen < 3'd4) begin
        code = ST_SHORT;
      end else if (crc_run != {held[1], held[0]}) begin
        code = ST_CRC;
      end else if (first_err != ST_OK) begin
        code = first_err;
      end else if (phase != PH_DONE) begin
        code = ST_TRUNCATED;
      end else begin
        code = ST_OK;
      end
      status             = '0;
      status.kind        = KIND_STATUS;
      status.seg_index   = seg_total;
      status.status_code = code;
      status.end_mark    = 1'b1;
      expected_items.push_back(status);
      clear_message();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    rsd_item_t want;
    if (expected_items.size() == 0) begin
      $error("unexpected result transaction: kind %0d seg_index %0d status_code %0d",
             out_if.kind, out_if.seg_index, out_if.status_code);
      fail_count++;
      return;
    end
    want = expected_items.pop_front();
    check_field("kind",         want.kind,         out_if.kind);
    check_field("seg_index",    want.seg_index,    out_if.seg_index);
    check_field("dist_milli",   want.dist_milli,   out_if.dist_milli);
    check_field("speed_deci",   want.speed_deci,   out_if.speed_deci);
    check_field("speed_given",  want.speed_given,  out_if.speed_given);
    check_field("dist_restart", want.dist_restart, out_if.dist_restart);
    check_field("is_free",      want.is_free,      out_if.is_free);
    check_field("chk_class",    want.chk_class,    out_if.chk_class);
    check_field("label_char",   want.label_char,   out_if.label_char);
    check_field("status_code",  want.status_code,  out_if.status_code);
    check_field("end_mark",     want.end_mark,     out_if.end_mark);
  endtask

  // Results from a byte are never taken in its own accepting cycle, so compare first.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_version = VERSION_RST;
      seg_limit     = LIMIT_RST;
      clear_message();
      expected_items.delete();
    end else begin
      if (out_if.valid && out_if.ready) begin
        check_result();
      end
      if (in_if.valid && in_if.ready) begin
        accept_byte(in_if.data_byte, in_if.last_byte);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_VERSION) begin
          proto_version = cfg_data_i;
        end else begin
          seg_limit = cfg_data_i;
        end
      end
    end
    pending = expected_items.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top for route_sheet_stream_decoder_top: clock, reset, message stimulus,
// random idling on both channels and the verdict. Depends on rsd_pkg, rsd_if.sv, rsd_checker.sv.
module tb
  import rsd_pkg::*;
  import rsd_tb_pkg::*;
;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BYTES  = 250;
  localparam int NUM_PHASES   = 6;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_idx = '0;
  logic [7:0] cfg_data = '0;

  int         fail_count;
  int         pending;
  int         cycle_count = 0;
  int         bytes_sent = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  logic [7:0] cur_version = VERSION_RST;
  logic [7:0] cur_limit = LIMIT_RST;
  logic [7:0] msg_bytes[$];

  rsd_byte_if in_if ();
  rsd_item_if out_if ();

  route_sheet_stream_decoder_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  rsd_tb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .out_if       (out_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else if (hold_req != hold_seen) begin
      hold_seen    = hold_req;
      hold_left    = HOLD_CYCLES;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic offer_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.data_byte = b;
    in_if.last_byte = last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_route();
    foreach (msg_bytes[i]) begin
      offer_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    end
  endtask

  task automatic append_crc(input logic [15:0] flip);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (msg_bytes[i]) begin
      c = crc_ccitt_next(c, msg_bytes[i]);
    end
    c = c ^ flip;
    msg_bytes.push_back(c[7:0]);
    msg_bytes.push_back(c[15:8]);
  endtask

  function automatic int unsigned pick_label_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(0, 4);
    if (r < 97) return $urandom_range(30, 36);
    return $urandom_range(37, 255);
  endfunction

  task automatic add_noise(input int unsigned n);
    repeat (n) msg_bytes.push_back(8'($urandom));
  endtask

  task automatic build_route(input logic [7:0] ver, input logic [7:0] n_seg);
    int unsigned n_lbl;
    msg_bytes.delete();
    msg_bytes.push_back(ver);
    msg_bytes.push_back(n_seg);
    for (int s = 0; s < n_seg; s++) begin
      add_noise(5);  // distance, speed, flags
      n_lbl = pick_label_len();
      msg_bytes.push_back(8'(n_lbl));
      add_noise(n_lbl);
    end
  endtask

  // Mostly well-formed sheets; the rest carries one kind of damage or is plain noise
  task automatic build_random_route();
    int unsigned r;
    int unsigned n_max;
    logic [7:0]  n_seg;
    r     = $urandom_range(99);
    n_max = (cur_limit < 4) ? cur_limit : 4;
    n_seg = 8'($urandom_range(0, n_max));
    if (r < 60) begin
      build_route(cur_version, n_seg);
      append_crc('0);
    end else if (r < 66) begin
      build_route(cur_version ^ 8'($urandom_range(1, 255)), n_seg);
      append_crc('0);
    end else if (r < 72) begin
      build_route(cur_version, 8'd0);
      msg_bytes[1] = (cur_limit == 8'd255) ? 8'd255 : 8'($urandom_range(cur_limit + 1, 255));
      add_noise($urandom_range(0, 6));
      append_crc('0);
    end else if (r < 78) begin
      build_route(cur_version, (n_seg == 8'd0) ? 8'd1 : n_seg);
      repeat ($urandom_range(1, msg_bytes.size() - 2)) void'(msg_bytes.pop_back());
      append_crc('0);
    end else if (r < 84) begin
      build_route(cur_version, n_seg);
      add_noise($urandom_range(1, 3));
      append_crc('0);
    end else if (r < 90) begin
      build_route(cur_version, n_seg);
      append_crc(16'($urandom_range(1, 65535)));
    end else if (r < 95) begin
      msg_bytes.delete();
      add_noise($urandom_range(1, 3));
    end else begin
      msg_bytes.delete();
      add_noise($urandom_range(2, 10));
      if ($urandom_range(1) != 0) append_crc('0);
    end
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk_i);
    cfg_we   = 1'b0;
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0] ver_set [NUM_PHASES];
    logic [7:0] lim_set [NUM_PHASES];
    int         gap_set [4];
    int         stall_set [4];
    int         phase_start;

    ver_set   = '{8'd1, 8'd0, 8'd255, 8'hA5, 8'd1, 8'h3C};
    lim_set   = '{8'd32, 8'd255, 8'd0, 8'd3, 8'd1, 8'd7};
    gap_set   = '{0, 60, 0, 24};
    stall_set = '{0, 0, 60, 24};

    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed sheets at the reset register values
    msg_bytes = {8'h5A};
    send_route();
    msg_bytes = {8'd1, 8'd0};
    append_crc('0);
    send_route();
    msg_bytes = {8'd7, 8'd0};
    append_crc('0);
    send_route();
    msg_bytes = {8'd1, 8'd0};
    append_crc(16'h8001);
    send_route();
    // all-ones fields, two-byte label
    msg_bytes = {8'd1, 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd2, 8'h00, 8'hFF};
    append_crc('0);
    send_route();
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      cur_version = ver_set[p];
      cur_limit   = lim_set[p];
      write_reg(REG_VERSION, cur_version);
      write_reg(REG_LIMIT, cur_limit);
      gap_pct   = gap_set[p % 4];
      stall_pct = stall_set[p % 4];
      // long receiver hold-off while the sender keeps going
      if (p == 0) hold_req++;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_random_route();
        send_route();
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
